// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the scheduler checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// types and constants shared by the deadline slot scheduler files
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int SLOT_W = 4;
  localparam int ST_W   = 3;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 5'd16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  localparam logic [ST_W-1:0] ST_RUNNING = 3'd3;
  localparam logic [ST_W-1:0] ST_SLEEP   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOW     = 3'd5;
  localparam logic [ST_W-1:0] ST_START   = 3'd6;

  localparam logic [TIME_W-1:0] DIST_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] nice_interval;
    logic [TIME_W-1:0] sleep_ticks;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [ST_W-1:0]   status;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] nice_interval;
    logic [TIME_W-1:0] sleep_ticks;
    logic [TIME_W-1:0] now_tick;
    logic [SLOT_W-1:0] current_slot;
  } sched_req_t;

  typedef struct packed {
    logic wr_slot;
    logic start_sched;
    logic scan_en;
    logic load_out;
  } dss_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dss_sts_t;

endpackage

// ===== rtl/core/dss_in_if.sv =====
// ----------------------------------------------------------------------------
// dss_in_if
// request channel: slot writes and schedule requests
// ----------------------------------------------------------------------------
interface dss_in_if import dss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [SLOT_W-1:0] slot;
  logic [ST_W-1:0]   status;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] nice_interval;
  logic [TIME_W-1:0] sleep_ticks;
  logic [TIME_W-1:0] now_tick;
  logic [SLOT_W-1:0] current_slot;

  modport source (
    output valid, op, slot, status, last_time, nice_interval, sleep_ticks,
           now_tick, current_slot,
    input  ready
  );
  modport sink (
    input  valid, op, slot, status, last_time, nice_interval, sleep_ticks,
           now_tick, current_slot,
    output ready
  );
endinterface

// ===== rtl/core/dss_out_if.sv =====
// ----------------------------------------------------------------------------
// dss_out_if
// result channel: chosen slot with found and immediate flags
// ----------------------------------------------------------------------------
interface dss_out_if import dss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] chosen_slot;
  logic              found;
  logic              immediate;

  modport source (output valid, chosen_slot, found, immediate, input ready);
  modport sink (input valid, chosen_slot, found, immediate, output ready);
endinterface

// ===== rtl/core/dss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dss_cfg_if
// configuration write channel for the slot count register
// ----------------------------------------------------------------------------
interface dss_cfg_if import dss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] slot_count;

  modport source (output valid, slot_count, input ready);
  modport sink (input valid, slot_count, output ready);
endinterface

// ===== rtl/core/dss_ram.sv =====
// ----------------------------------------------------------------------------
// dss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// sequencer: takes a request, runs the slot scan, hands off the result
// ----------------------------------------------------------------------------
module dss_ctrl import dss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  dss_sts_t sts,
  output dss_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_SCHED) begin
            cmd.start_sched = 1'b1;
            state_nxt       = S_SCAN;
          end else begin
            cmd.wr_slot = 1'b1;
            state_nxt   = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/dss_datapath.sv =====
// ----------------------------------------------------------------------------
// dss_datapath
// slot table, scan pipeline (read, due time, distance compare), result reg
// ----------------------------------------------------------------------------
module dss_datapath import dss_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sched_req_t        req,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  dss_cmd_t          cmd,
  output dss_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_chosen_slot,
  output logic              out_found,
  output logic              out_immediate
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int PW = (CW > CNT_W) ? CW : CNT_W;

  // configuration
  logic [CNT_W-1:0] slot_count_r;

  // table valid bits, cleared by reset; an unwritten slot reads as free
  logic [MAX_SLOTS-1:0] valid_r;
  logic [MAX_SLOTS-1:0] valid_nxt;

  // scan control
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     pos_r;
  logic [AW-1:0]     pos_nxt;
  logic [CW-1:0]     issue_cnt_r;
  logic [TIME_W-1:0] now_r;
  logic              hit_r;

  // pipeline stages
  logic              s1_vld_r;
  logic              s1_ent_r;
  logic [AW-1:0]     s1_pos_r;
  slot_rec_t         rd_rec;
  logic [REC_W-1:0]  rd_data;
  logic              s2_vld_r;
  logic              s2_elig_r;
  logic              s2_fast_r;
  logic [TIME_W-1:0] s2_due_r;
  logic [AW-1:0]     s2_pos_r;

  // running result
  logic [TIME_W-1:0] best_r;
  logic [SLOT_W-1:0] pick_r;
  logic              found_r;
  logic              imm_r;

  // output register
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_found_r;
  logic              out_imm_r;

  logic [PW-1:0]     cnt_lim;
  logic [PW-1:0]     cur_inc;
  logic [AW-1:0]     start_pos;
  logic              wr_in_range;
  logic              ram_we;
  logic              issue;
  logic [ST_W-1:0]   st1;
  logic [TIME_W-1:0] add1;
  logic [TIME_W:0]   diff2;
  logic              eval2;
  logic              hit2;
  logic              better2;

  // effective count and first scan position
  always_comb begin
    cnt_lim = (PW'(slot_count_r) > PW'(MAX_SLOTS)) ? PW'(MAX_SLOTS) : PW'(slot_count_r);
    cur_inc = PW'(req.current_slot) + PW'(1);
    start_pos = (cur_inc >= cnt_lim) ? '0 : AW'(cur_inc);
  end

  assign wr_in_range = (PW'(req.slot) < PW'(MAX_SLOTS));
  assign ram_we      = cmd.wr_slot && wr_in_range;

  always_comb begin
    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[AW'(req.slot)] = 1'b1;
    end
  end

  assign issue   = cmd.scan_en && !hit_r && (issue_cnt_r != count_r);
  assign pos_nxt = ((CW'(pos_r) + CW'(1)) == count_r) ? '0 : pos_r + AW'(1);

  dss_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.slot)),
    .wdata ({req.status, req.last_time, req.nice_interval, req.sleep_ticks}),
    .re    (issue),
    .raddr (pos_r),
    .rdata (rd_data)
  );

  assign rd_rec = slot_rec_t'(rd_data);

  // stage 1: due time
  always_comb begin
    st1  = s1_ent_r ? rd_rec.status : '0;
    add1 = (st1 == ST_SLEEP) ? rd_rec.sleep_ticks : rd_rec.nice_interval;
  end

  // stage 2: overdue test and distance compare, borrow means due < now
  always_comb begin
    diff2   = {1'b0, s2_due_r} - {1'b0, now_r};
    eval2   = cmd.scan_en && s2_vld_r && !hit_r && s2_elig_r;
    hit2    = eval2 && (diff2[TIME_W] || s2_fast_r);
    better2 = eval2 && !hit2 && (diff2[TIME_W-1:0] < best_r);
  end

  assign sts.scan_done = hit_r || ((issue_cnt_r == count_r) && !s1_vld_r && !s2_vld_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
      valid_r      <= '0;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_count_r <= cfg_data;
      end
      valid_r <= valid_nxt;
      if (cmd.start_sched) begin
        s1_vld_r <= 1'b0;
        s2_vld_r <= 1'b0;
        hit_r    <= 1'b0;
      end else begin
        s1_vld_r <= issue;
        s2_vld_r <= s1_vld_r;
        if (hit2) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sched) begin
      count_r     <= CW'(cnt_lim);
      pos_r       <= start_pos;
      issue_cnt_r <= '0;
      now_r       <= req.now_tick;
    end else if (issue) begin
      pos_r       <= pos_nxt;
      issue_cnt_r <= issue_cnt_r + CW'(1);
    end

    s1_ent_r  <= valid_r[pos_r];
    s1_pos_r  <= pos_r;
    s2_elig_r <= (st1 >= ST_RUNNING);
    s2_fast_r <= (st1 == ST_START) || (st1 == ST_NOW);
    s2_due_r  <= rd_rec.last_time + add1;
    s2_pos_r  <= s1_pos_r;

    if (cmd.start_sched) begin
      best_r  <= DIST_NONE;
      pick_r  <= req.current_slot;
      found_r <= 1'b0;
      imm_r   <= 1'b0;
    end else if (cmd.wr_slot) begin
      pick_r  <= '0;
      found_r <= 1'b0;
      imm_r   <= 1'b0;
    end else if (hit2) begin
      pick_r  <= SLOT_W'(s2_pos_r);
      found_r <= 1'b1;
      imm_r   <= 1'b1;
    end else if (better2) begin
      best_r  <= diff2[TIME_W-1:0];
      pick_r  <= SLOT_W'(s2_pos_r);
      found_r <= 1'b1;
    end

    if (cmd.load_out) begin
      out_slot_r  <= pick_r;
      out_found_r <= found_r;
      out_imm_r   <= imm_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_slot = out_slot_r;
  assign out_found       = out_found_r;
  assign out_immediate   = out_imm_r;

endmodule

// ===== rtl/core/deadline_slot_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_slot_scheduler_unit
// thread slot table with a rotating deadline scan picking the next slot
// ----------------------------------------------------------------------------
// One request at a time. A slot write goes through the finish state straight to
// the output register, with no scan. A schedule request scans N entries, where N is the
// effective slot count (slot_count limited to MAX_SLOTS): the scan reads one
// table entry per cycle from the slot ram, and each entry then passes a due
// time stage and a distance compare stage; an immediate pick ends the scan
// early. A new request is taken while a finished result still waits in the
// output register. slot_count is written through the cfg channel, which is
// always ready; write it only while no request is in flight.
module deadline_slot_scheduler_unit import dss_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  dss_in_if.sink     in_ch,
  dss_out_if.source  out_ch,
  dss_cfg_if.sink    cfg_ch
);

  sched_req_t req;
  dss_cmd_t   cmd;
  dss_sts_t   sts;

  assign req.op            = in_ch.op;
  assign req.slot          = in_ch.slot;
  assign req.status        = in_ch.status;
  assign req.last_time     = in_ch.last_time;
  assign req.nice_interval = in_ch.nice_interval;
  assign req.sleep_ticks   = in_ch.sleep_ticks;
  assign req.now_tick      = in_ch.now_tick;
  assign req.current_slot  = in_ch.current_slot;

  assign cfg_ch.ready = 1'b1;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (req.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dss_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.slot_count),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_chosen_slot (out_ch.chosen_slot),
    .out_found       (out_ch.found),
    .out_immediate   (out_ch.immediate)
  );

endmodule

// ===== rtl/core/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker
// port-level assertions for the deadline slot scheduler, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dss_checker import dss_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_chosen_slot,
  input logic              out_found,
  input logic              out_immediate
);

  `DSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `DSS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_chosen_slot) && $stable(out_found) && $stable(out_immediate), "result changed while stalled")
  // one request in flight: ready drops right after a request is taken
  `DSS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken while busy")
  `DSS_ASSERT_IMPL(a_imm_found, clk, rst_n, out_valid && out_immediate, out_found, "immediate pick without found")

endmodule

bind deadline_slot_scheduler_unit dss_checker u_dss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_chosen_slot (out_ch.chosen_slot),
  .out_found       (out_ch.found),
  .out_immediate   (out_ch.immediate)
);

// ===== tb/deadline_slot_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_slot_scheduler_unit_tb
// self-checking bench for the deadline slot scheduler
// ----------------------------------------------------------------------------
// Drives slot writes and schedule requests with random gaps on both sides,
// keeps its own copy of the slot table and scan count, and checks every
// result against the pick it works out itself. Runs a directed set first,
// then random traffic at several slot counts and one long result stall.
// ----------------------------------------------------------------------------
module deadline_slot_scheduler_unit_tb;
  import dss_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  // status codes the package leaves out
  localparam logic [ST_W-1:0] ST_FREE      = 3'd0;
  localparam logic [ST_W-1:0] ST_WAIT_TAG  = 3'd1;
  localparam logic [ST_W-1:0] ST_WAIT_LOCK = 3'd2;
  localparam logic [ST_W-1:0] ST_RESERVED  = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0] chosen_slot;
    logic              found;
    logic              immediate;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dss_in_if  in_ch ();
  dss_out_if out_ch ();
  dss_cfg_if cfg_ch ();

  deadline_slot_scheduler_unit #(.MAX_SLOTS(TABLE_SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow slot table and scan count
  logic [ST_W-1:0]   tbl_status [TABLE_SLOTS];
  logic [TIME_W-1:0] tbl_last   [TABLE_SLOTS];
  logic [TIME_W-1:0] tbl_nice   [TABLE_SLOTS];
  logic [TIME_W-1:0] tbl_sleep  [TABLE_SLOTS];
  logic [CNT_W-1:0]  scan_count;

  pick_t pending_picks [$];

  bit idle_on;
  bit hold_req;
  int mismatch_count;
  int results_checked;
  int write_reqs;
  int sched_reqs;
  int immediate_picks;
  int deferred_picks;
  int kept_current;

  function automatic pick_t next_slot_pick(input logic [TIME_W-1:0] now,
                                           input logic [SLOT_W-1:0] cur);
    pick_t             p;
    int                count;
    int                pos;
    int                n;
    bit                done;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] due_gap;
    logic [TIME_W-1:0] best;
    count = (scan_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(scan_count);
    p.chosen_slot = cur;
    p.found = 1'b0;
    p.immediate = 1'b0;
    best = DIST_NONE;
    pos = int'(cur) + 1;
    done = 1'b0;
    for (n = 0; n < count && !done; n++) begin
      if (pos >= count) pos = 0;
      if (tbl_status[pos] >= ST_RUNNING) begin
        due = tbl_last[pos] + ((tbl_status[pos] == ST_SLEEP) ? tbl_sleep[pos] : tbl_nice[pos]);
        due_gap = due - now;
        if (due < now || tbl_status[pos] == ST_START || tbl_status[pos] == ST_NOW) begin
          p.chosen_slot = pos[SLOT_W-1:0];
          p.found = 1'b1;
          p.immediate = 1'b1;
          done = 1'b1;
        end else if (due_gap < best) begin
          best = due_gap;
          p.chosen_slot = pos[SLOT_W-1:0];
          p.found = 1'b1;
        end
      end
      pos++;
    end
    return p;
  endfunction

  // update the shadow table for an accepted request and queue its result
  function automatic void apply_request(input sched_req_t r);
    pick_t p;
    if (r.op == OP_WRITE) begin
      // a 4-bit slot always lands inside the table
      tbl_status[r.slot] = r.status;
      tbl_last[r.slot]   = r.last_time;
      tbl_nice[r.slot]   = r.nice_interval;
      tbl_sleep[r.slot]  = r.sleep_ticks;
      p = '0;
      write_reqs++;
    end else begin
      p = next_slot_pick(r.now_tick, r.current_slot);
      sched_reqs++;
      if (p.immediate) immediate_picks++;
      else if (p.found) deferred_picks++;
      else kept_current++;
    end
    pending_picks.push_back(p);
  endfunction

  function automatic sched_req_t make_write(input logic [SLOT_W-1:0] s,
                                            input logic [ST_W-1:0] st,
                                            input logic [TIME_W-1:0] last,
                                            input logic [TIME_W-1:0] nice,
                                            input logic [TIME_W-1:0] sleep_t);
    sched_req_t r;
    r.op = OP_WRITE;
    r.slot = s;
    r.status = st;
    r.last_time = last;
    r.nice_interval = nice;
    r.sleep_ticks = sleep_t;
    r.now_tick = $urandom();
    r.current_slot = SLOT_W'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic sched_req_t make_sched(input logic [TIME_W-1:0] now,
                                            input logic [SLOT_W-1:0] cur);
    sched_req_t r;
    r.op = OP_SCHED;
    r.slot = SLOT_W'($urandom_range(0, 15));
    r.status = ST_W'($urandom_range(0, 7));
    r.last_time = $urandom();
    r.nice_interval = $urandom();
    r.sleep_ticks = $urandom();
    r.now_tick = now;
    r.current_slot = cur;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] span_ticks();
    return ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 300);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_request(input sched_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op            = r.op;
    in_ch.slot          = r.slot;
    in_ch.status        = r.status;
    in_ch.last_time     = r.last_time;
    in_ch.nice_interval = r.nice_interval;
    in_ch.sleep_ticks   = r.sleep_ticks;
    in_ch.now_tick      = r.now_tick;
    in_ch.current_slot  = r.current_slot;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_request(r);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_ch.valid = 1'b0;
    while (pending_picks.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_slot_count(input logic [CNT_W-1:0] cnt);
    wait_for_idle();
    cfg_ch.slot_count = cnt;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    scan_count = cnt;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // result checker
  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.chosen_slot = out_ch.chosen_slot;
      got.found = out_ch.found;
      got.immediate = out_ch.immediate;
      if (pending_picks.size() == 0) begin
        note_failure($sformatf("result with no request pending: slot %0d found %0b immediate %0b",
                               got.chosen_slot, got.found, got.immediate));
      end else begin
        want = pending_picks.pop_front();
        results_checked++;
        if (got.chosen_slot !== want.chosen_slot || got.found !== want.found ||
            got.immediate !== want.immediate) begin
          note_failure($sformatf({"expected slot %0d found %0b immediate %0b, ",
                                  "got slot %0d found %0b immediate %0b"},
                                 want.chosen_slot, want.found, want.immediate,
                                 got.chosen_slot, got.found, got.immediate));
        end
      end
    end
  end

  // result side ready: random stalls per result, plus a long hold on request
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    bit  took;
    out_ch.ready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      took = out_ch.valid && out_ch.ready;
      @(negedge clk);
      if (took) stall_left = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_picks.size());
    $display("Verification failed");
    $finish;
  end

  task automatic test_empty_table();
    issue_request(make_sched(32'h0, 4'd0));
    issue_request(make_sched(32'hFFFF_FFFF, 4'd15));
  endtask

  task automatic test_immediate_picks();
    // status seven behaves like running, overdue at the top of the tick range
    issue_request(make_write(4'd15, ST_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    issue_request(make_sched(32'hFFFF_FFFF, 4'd0));
    issue_request(make_write(4'd0, ST_START, 32'h0, 32'h0, 32'hFFFF_FFFF));
    issue_request(make_sched(32'h0, 4'd15));
    issue_request(make_write(4'd0, ST_FREE, 32'h0, 32'h0, 32'h0));
    issue_request(make_write(4'd3, ST_NOW, 32'h0, 32'h0, 32'h0));
    // slot 15 is a candidate first, then the now slot wins outright
    issue_request(make_sched(32'h0, 4'd3));
  endtask

  task automatic test_deferred_picks();
    issue_request(make_write(4'd3, ST_WAIT_LOCK, 32'h0, 32'h0, 32'h0));
    issue_request(make_write(4'd15, ST_WAIT_TAG, 32'h0, 32'h0, 32'h0));
    // sleeping slot uses its sleep time, running slot ties with it
    issue_request(make_write(4'd5, ST_SLEEP, 32'd100, 32'd0, 32'd50));
    issue_request(make_write(4'd8, ST_RUNNING, 32'd0, 32'd150, 32'd0));
    issue_request(make_sched(32'd120, 4'd6));
    issue_request(make_sched(32'd120, 4'd4));
    issue_request(make_sched(32'd200, 4'd0));
    issue_request(make_write(4'd5, ST_FREE, 32'h0, 32'h0, 32'h0));
    // distance of all ones never wins
    issue_request(make_write(4'd8, ST_RUNNING, 32'hFFFF_FFFF, 32'h0, 32'h0));
    issue_request(make_sched(32'h0, 4'd8));
    issue_request(make_sched(32'hFFFF_FFFF, 4'd7));
  endtask

  task automatic test_slot_count_edges();
    set_slot_count(5'd0);
    issue_request(make_sched(32'h1234, 4'd5));
    set_slot_count(5'd1);
    issue_request(make_write(4'd0, ST_RUNNING, 32'd0, 32'd10, 32'd0));
    // current slot beyond the count wraps to slot 0
    issue_request(make_sched(32'd5, 4'd9));
    set_slot_count(5'd31);
    issue_request(make_sched(32'd0, 4'd15));
  endtask

  // bursts of slot writes followed by schedule requests near the same ticks
  task automatic test_random_traffic(input logic [CNT_W-1:0] cnt, input int n_items,
                                     input bit idle);
    int                sent;
    int                eff;
    int                burst;
    int                k;
    int                pick;
    logic [ST_W-1:0]   st;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] base;
    sched_req_t        r;
    set_slot_count(cnt);
    idle_on = idle;
    eff = (cnt > TABLE_SLOTS) ? TABLE_SLOTS : int'(cnt);
    base = $urandom_range(0, 1) ? $urandom() : (32'hFFFF_FF00 + $urandom_range(0, 255));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any value in every field
        r.op = 1'($urandom_range(0, 1));
        r.slot = SLOT_W'($urandom_range(0, 15));
        r.status = ST_W'($urandom_range(0, 7));
        r.last_time = $urandom();
        r.nice_interval = $urandom();
        r.sleep_ticks = $urandom();
        r.now_tick = $urandom();
        r.current_slot = SLOT_W'($urandom_range(0, 15));
        issue_request(r);
        sent++;
      end else begin
        burst = $urandom_range(1, 5);
        for (k = 0; k < burst; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 5) st = ST_W'($urandom_range(0, 2));
          else if (pick < 9) st = ST_RUNNING;
          else if (pick < 14) st = ST_SLEEP;
          else if (pick < 16) st = ST_RESERVED;
          else if (pick < 18) st = ST_NOW;
          else st = ST_START;
          s = (eff > 0 && $urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, eff - 1))
                                                     : SLOT_W'($urandom_range(0, 15));
          issue_request(make_write(s, st, base - $urandom_range(0, 255), span_ticks(),
                                   span_ticks()));
          sent++;
        end
        burst = $urandom_range(1, 3);
        for (k = 0; k < burst; k++) begin
          issue_request(make_sched(base + $urandom_range(0, 255),
                                   SLOT_W'($urandom_range(0, 15))));
          base = base + $urandom_range(0, 64);
          sent++;
        end
      end
    end
  endtask

  task automatic test_result_backpressure();
    int k;
    set_slot_count(5'd16);
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) begin
      if (k % 4 == 0)
        issue_request(make_write(SLOT_W'($urandom_range(0, 15)), ST_RUNNING,
                                 $urandom_range(0, 100), $urandom_range(0, 100), $urandom()));
      else
        issue_request(make_sched($urandom_range(0, 200), SLOT_W'($urandom_range(0, 15))));
    end
    idle_on = 1'b1;
  endtask

  initial begin : main_seq
    int i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.slot = '0;
    in_ch.status = '0;
    in_ch.last_time = '0;
    in_ch.nice_interval = '0;
    in_ch.sleep_ticks = '0;
    in_ch.now_tick = '0;
    in_ch.current_slot = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.slot_count = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    mismatch_count = 0;
    results_checked = 0;
    write_reqs = 0;
    sched_reqs = 0;
    immediate_picks = 0;
    deferred_picks = 0;
    kept_current = 0;
    scan_count = SLOT_COUNT_RST;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      tbl_status[i] = ST_FREE;
      tbl_last[i] = '0;
      tbl_nice[i] = '0;
      tbl_sleep[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_immediate_picks();
    test_deferred_picks();
    test_slot_count_edges();
    test_random_traffic(5'd16, 500, 1'b1);
    test_random_traffic(5'd1, 100, 1'b1);
    test_random_traffic(5'd4, 250, 1'b0);
    test_result_backpressure();
    test_random_traffic(5'd0, 40, 1'b1);
    test_random_traffic(5'd31, 300, 1'b1);
    test_random_traffic(5'd17, 150, 1'b0);
    test_random_traffic(5'd9, 200, 1'b1);
    test_random_traffic(5'd16, 250, 1'b0);

    wait_for_idle();
    repeat (30) @(negedge clk);
    $display("covered %0d slot writes and %0d schedule requests over slot counts 0 to 31",
             write_reqs, sched_reqs);
    $display("checked %0d results: %0d immediate, %0d by nearest due time, %0d kept current",
             results_checked, immediate_picks, deferred_picks, kept_current);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
